/* hw/rtl/fac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_pkg
// Shared types and constants of the frustum box culling unit.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int NUM_PLANES_DEF  = 6;
  localparam int COORD_WIDTH_DEF = 32;

  // Width of every coordinate field on the input bus.
  localparam int FIELD_W = 32;

  // Coordinate slots that travel down the cell chain with each beat.
  // A test carries min x/y/z in slots 0..2 and max x/y/z in slots 3..5.
  // A load carries normal x/y/z in slots 0..2 and the offset in slot 3.
  localparam int NUM_SLOTS = 6;
  localparam int NUM_AXES  = 3;
  localparam int SLOT_OFF  = 3;

  // Fraction bits of the Q16.16 format; the offset is aligned to the products.
  localparam int Q_FRAC = 16;

  localparam int PLANE_CODE_W = 3;

  localparam int IN_TDATA_W  = 10 * FIELD_W;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 1;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [PLANE_CODE_W-1:0] plane_index;
    logic                    culled;
    logic [PLANE_CODE_W-1:0] cull_plane;
  } ctrl_t;

endpackage

/* hw/rtl/fac_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_cell
// One plane of the culling chain: holds the plane, tests the passing box
// against it over two register stages (products, then sum and sign).
// ----------------------------------------------------------------------------
module fac_cell #(
  parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF,
  parameter int CELL_ID     = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fac_pkg::ctrl_t                in_ctrl,
  input  logic signed [COORD_WIDTH-1:0] in_coord [fac_pkg::NUM_SLOTS],
  output logic                          out_valid,
  input  logic                          out_ready,
  output fac_pkg::ctrl_t                out_ctrl,
  output logic signed [COORD_WIDTH-1:0] out_coord [fac_pkg::NUM_SLOTS]
);

  localparam int PW = 2 * COORD_WIDTH;
  localparam int SW = 2 * COORD_WIDTH + 2;

  logic signed [COORD_WIDTH-1:0] nrm [fac_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] off;

  logic signed [COORD_WIDTH-1:0] vtx [fac_pkg::NUM_AXES];
  logic signed [PW-1:0]          prod_next [fac_pkg::NUM_AXES];

  logic                          a_valid;
  fac_pkg::ctrl_t                a_ctrl;
  logic signed [COORD_WIDTH-1:0] a_coord [fac_pkg::NUM_SLOTS];
  logic signed [PW-1:0]          a_prod [fac_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] a_off;

  logic                          b_valid;
  fac_pkg::ctrl_t                b_ctrl;
  fac_pkg::ctrl_t                b_ctrl_next;
  logic signed [COORD_WIDTH-1:0] b_coord [fac_pkg::NUM_SLOTS];

  logic signed [SW-1:0] off_ext;
  logic signed [SW-1:0] off_term;
  logic signed [SW-1:0] plane_dist;

  logic en_a;
  logic en_b;
  logic wr;

  assign en_b     = !b_valid || out_ready;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  assign wr = in_valid && en_a && (in_ctrl.cmd == fac_pkg::CMD_LOAD) &&
              (32'(in_ctrl.plane_index) == 32'(CELL_ID));

  // Plane storage; loads pass through the chain in order, so a box behind a
  // load sees the new plane and a box ahead of it sees the old one.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fac_pkg::NUM_AXES; i++) begin
        nrm[i] <= '0;
      end
      off <= '0;
    end else if (wr) begin
      for (int i = 0; i < fac_pkg::NUM_AXES; i++) begin
        nrm[i] <= in_coord[i];
      end
      off <= in_coord[fac_pkg::SLOT_OFF];
    end
  end

  // Positive vertex: max corner where the normal is strictly positive.
  always_comb begin
    for (int i = 0; i < fac_pkg::NUM_AXES; i++) begin
      vtx[i] = (!nrm[i][COORD_WIDTH-1] && (nrm[i] != '0)) ?
               in_coord[fac_pkg::NUM_AXES + i] : in_coord[i];
      prod_next[i] = nrm[i] * vtx[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_ctrl  <= in_ctrl;
      a_coord <= in_coord;
      a_prod  <= prod_next;
      a_off   <= off;
    end
  end

  always_comb begin
    off_ext     = a_off;
    off_term    = off_ext <<< fac_pkg::Q_FRAC;
    plane_dist  = a_prod[0] + a_prod[1] + a_prod[2] + off_term;
    b_ctrl_next = a_ctrl;
    if ((a_ctrl.cmd == fac_pkg::CMD_TEST) && !a_ctrl.culled && plane_dist[SW-1]) begin
      b_ctrl_next.culled     = 1'b1;
      b_ctrl_next.cull_plane = fac_pkg::PLANE_CODE_W'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_ctrl  <= b_ctrl_next;
      b_coord <= a_coord;
    end
  end

  assign out_valid = b_valid;
  assign out_ctrl  = b_ctrl;
  assign out_coord = b_coord;

endmodule

/* hw/rtl/frustum_aabb_cull_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_aabb_cull_unit
// Tests axis-aligned boxes against a set of stored frustum planes.
// ----------------------------------------------------------------------------
// Input beats on s_axis: tuser selects a plane load or a box test. A load
// writes normal and offset into the plane named by plane_index (indexes at or
// above NUM_PLANES write nothing) and is acknowledged by one result beat with
// was_test low. A test carries the min and max corners of a box and returns
// culled and the index of the first plane that has the positive vertex
// strictly behind it, or NUM_PLANES (low three bits) when none does.
// Every input beat gives exactly one result beat on m_axis, in order.
// Each beat passes 2 * NUM_PLANES + 1 registers, a product and a sum register
// per plane cell and then one output register. One beat is accepted per
// cycle unless a full chain is held by a low m_axis_tready; every cell holds
// its own plane, so loads and tests may be mixed freely beat after beat.
// Reset clears all planes to zero (a zero plane never culls) and empties the
// chain. When m_axis_tready is low the chain keeps accepting beats until all
// of its stages are full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_unit #(
  parameter int NUM_PLANES  = fac_pkg::NUM_PLANES_DEF,
  parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // normal_x, normal_y, normal_z, offset_d, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z, 32 bits each
  input  logic [fac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd [0], plane_index [3:1]
  input  logic [fac_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // culled [0], cull_plane [3:1], zero [7:4]
  output logic [fac_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // was_test [0]
  output logic [fac_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int FW = fac_pkg::FIELD_W;

  logic                          ch_valid [NUM_PLANES+1];
  logic                          ch_ready [NUM_PLANES+1];
  fac_pkg::ctrl_t                ch_ctrl  [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0] ch_coord [NUM_PLANES+1][fac_pkg::NUM_SLOTS];

  fac_pkg::ctrl_t                in_ctrl;
  logic signed [COORD_WIDTH-1:0] in_coord [fac_pkg::NUM_SLOTS];

  logic           o_valid;
  fac_pkg::ctrl_t o_ctrl;
  fac_pkg::ctrl_t o_ctrl_next;
  logic           o_en;

  // Load and test share the coordinate slots of the chain.
  always_comb begin
    in_ctrl.cmd         = fac_pkg::cmd_t'(s_axis_tuser[0]);
    in_ctrl.plane_index = s_axis_tuser[3:1];
    in_ctrl.culled      = 1'b0;
    in_ctrl.cull_plane  = '0;
    if (in_ctrl.cmd == fac_pkg::CMD_TEST) begin
      for (int i = 0; i < fac_pkg::NUM_SLOTS; i++) begin
        in_coord[i] = s_axis_tdata[(4 + i) * FW +: COORD_WIDTH];
      end
    end else begin
      for (int i = 0; i < fac_pkg::NUM_SLOTS; i++) begin
        in_coord[i] = (i <= fac_pkg::SLOT_OFF) ? s_axis_tdata[i * FW +: COORD_WIDTH] : '0;
      end
    end
  end

  assign ch_valid[0]   = s_axis_tvalid;
  assign ch_ctrl[0]    = in_ctrl;
  assign ch_coord[0]   = in_coord;
  assign s_axis_tready = ch_ready[0];

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    fac_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .CELL_ID     (p)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (ch_valid[p]),
      .in_ready  (ch_ready[p]),
      .in_ctrl   (ch_ctrl[p]),
      .in_coord  (ch_coord[p]),
      .out_valid (ch_valid[p+1]),
      .out_ready (ch_ready[p+1]),
      .out_ctrl  (ch_ctrl[p+1]),
      .out_coord (ch_coord[p+1])
    );
  end

  // Output register.
  assign o_en                 = !o_valid || m_axis_tready;
  assign ch_ready[NUM_PLANES] = o_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_en) begin
      o_valid <= ch_valid[NUM_PLANES];
    end
  end

  always_comb begin
    o_ctrl_next = ch_ctrl[NUM_PLANES];
    if ((ch_ctrl[NUM_PLANES].cmd == fac_pkg::CMD_TEST) && !ch_ctrl[NUM_PLANES].culled) begin
      o_ctrl_next.cull_plane = fac_pkg::PLANE_CODE_W'(NUM_PLANES);
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      o_ctrl <= o_ctrl_next;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {4'b0000, o_ctrl.cull_plane, o_ctrl.culled};
  assign m_axis_tuser  = o_ctrl.cmd;

endmodule

/* hw/rtl/fac_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_checker
// Port-level checks of the frustum box culling unit, bound to the top level.
// ----------------------------------------------------------------------------
module fac_checker #(
  parameter int NUM_PLANES = fac_pkg::NUM_PLANES_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fac_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [fac_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Reset empties the chain and the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat present right after reset");

  // A load acknowledgment carries no cull information.
  a_load_ack: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] == fac_pkg::CMD_LOAD) |->
      m_axis_tdata[3:0] == 4'b0000)
    else $error("load acknowledgment with cull fields set");

  // A box that survives reports the plane count as its plane code.
  a_no_cull_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser[0] == fac_pkg::CMD_TEST) && !m_axis_tdata[0] |->
      m_axis_tdata[3:1] == fac_pkg::PLANE_CODE_W'(NUM_PLANES))
    else $error("kept box reports a culling plane");

endmodule

bind frustum_aabb_cull_unit fac_checker #(
  .NUM_PLANES (NUM_PLANES)
) u_fac_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the frustum box culling unit.
// ----------------------------------------------------------------------------
// Plane loads and box tests are driven on s_axis in random bursts. A checker
// class keeps its own copy of the six planes and works out, for each accepted test
// beat, the exact signed distance of the positive vertex to every plane. It
// then compares each m_axis result beat with the oldest prediction. The
// receiver stalls on its own changing pattern, and a watchdog ends the run
// when no beat moves for too long.
// ----------------------------------------------------------------------------
module tb;

  localparam int NP             = fac_pkg::NUM_PLANES_DEF;
  localparam int LATENCY        = 2 * NP + 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 450;
  localparam logic [31:0] ONE   = 32'h0001_0000;

  typedef struct {
    fac_pkg::cmd_t                    cmd;
    logic [fac_pkg::PLANE_CODE_W-1:0] plane_index;
    logic [fac_pkg::IN_TDATA_W-1:0]   data;
  } beat_t;

  typedef struct {
    logic                             was_test;
    logic                             culled;
    logic [fac_pkg::PLANE_CODE_W-1:0] cull_plane;
  } verdict_t;

  class cull_checker;
    logic signed [31:0] pl_nx [NP];
    logic signed [31:0] pl_ny [NP];
    logic signed [31:0] pl_nz [NP];
    logic signed [31:0] pl_off [NP];
    verdict_t verdict_q[$];
    int errors;

    function new();
      for (int i = 0; i < NP; i++) begin
        pl_nx[i] = '0;
        pl_ny[i] = '0;
        pl_nz[i] = '0;
        pl_off[i] = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    // Predicts the result of one accepted input beat.
    function void note_beat(input beat_t b);
      verdict_t v;
      logic signed [31:0] n [3];
      logic signed [31:0] lo [3];
      logic signed [31:0] hi [3];
      logic signed [67:0] plane_dist;
      v.was_test = 1'b0;
      v.culled = 1'b0;
      v.cull_plane = '0;
      if (b.cmd == fac_pkg::CMD_LOAD) begin
        if (b.plane_index < NP) begin
          pl_nx[b.plane_index] = b.data[31:0];
          pl_ny[b.plane_index] = b.data[63:32];
          pl_nz[b.plane_index] = b.data[95:64];
          pl_off[b.plane_index] = b.data[127:96];
        end
      end else begin
        v.was_test = 1'b1;
        v.cull_plane = fac_pkg::PLANE_CODE_W'(NP);
        for (int a = 0; a < 3; a++) begin
          lo[a] = b.data[128 + 32 * a +: 32];
          hi[a] = b.data[224 + 32 * a +: 32];
        end
        // Walk the planes from the last one down so the first culling plane wins.
        for (int p = NP - 1; p >= 0; p--) begin
          n[0] = pl_nx[p];
          n[1] = pl_ny[p];
          n[2] = pl_nz[p];
          plane_dist = pl_off[p];
          plane_dist = plane_dist * 68'sd65536;
          for (int a = 0; a < 3; a++) begin
            plane_dist = plane_dist + n[a] * ((n[a] > 0) ? hi[a] : lo[a]);
          end
          if (plane_dist < 0) begin
            v.culled = 1'b1;
            v.cull_plane = fac_pkg::PLANE_CODE_W'(p);
          end
        end
      end
      verdict_q.push_back(v);
    endfunction

    function void check_verdict(input logic [fac_pkg::OUT_TDATA_W-1:0] tdata,
                                input logic [fac_pkg::OUT_TUSER_W-1:0] tuser);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $display("%0t: result beat with nothing predicted, tdata %0h tuser %0h",
                 $time, tdata, tuser);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (tuser[0] !== v.was_test) begin
        $display("%0t: was_test expected %0d actual %0d", $time, v.was_test, tuser[0]);
        errors++;
      end
      if (tdata[0] !== v.culled) begin
        $display("%0t: culled expected %0d actual %0d", $time, v.culled, tdata[0]);
        errors++;
      end
      if (tdata[3:1] !== v.cull_plane) begin
        $display("%0t: cull_plane expected %0d actual %0d", $time, v.cull_plane,
                 tdata[3:1]);
        errors++;
      end
      if (tdata[7:4] !== 4'b0000) begin
        $display("%0t: padding bits expected 0 actual %0h", $time, tdata[7:4]);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [fac_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [fac_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [fac_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [fac_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

  cull_checker sb;
  int burst_left;
  int idle_cycles;

  frustum_aabb_cull_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic beat_t load_beat(input int idx, input logic [31:0] nx,
                                      input logic [31:0] ny, input logic [31:0] nz,
                                      input logic [31:0] d);
    beat_t b;
    b.cmd = fac_pkg::CMD_LOAD;
    b.plane_index = fac_pkg::PLANE_CODE_W'(idx);
    b.data = '0;
    b.data[127:0] = {d, nz, ny, nx};
    // The box slots carry noise so that a load is not told apart by them.
    b.data[319:128] = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return b;
  endfunction

  function automatic beat_t test_beat(input logic [31:0] mnx, input logic [31:0] mny,
                                      input logic [31:0] mnz, input logic [31:0] mxx,
                                      input logic [31:0] mxy, input logic [31:0] mxz);
    beat_t b;
    b.cmd = fac_pkg::CMD_TEST;
    b.plane_index = fac_pkg::PLANE_CODE_W'($urandom_range(0, 7));
    b.data[127:0] = {$urandom, $urandom, $urandom, $urandom};
    b.data[319:128] = {mxz, mxy, mxx, mnz, mny, mnx};
    return b;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h200_0000)) - 32'h100_0000;
    endcase
  endfunction

  // Sends one beat, opening a new burst after a random gap when the last one ran out.
  task automatic push_beat(input beat_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b.data;
    s_axis_tuser <= {b.plane_index, b.cmd};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(b);
  endtask

  task automatic push_random_box();
    logic [31:0] a [3];
    logic [31:0] c [3];
    logic [31:0] t;
    for (int k = 0; k < 3; k++) begin
      a[k] = rand_coord();
      c[k] = rand_coord();
      // Most boxes are well formed; the rest keep whatever order they got.
      if ($urandom_range(0, 7) != 0 && $signed(a[k]) > $signed(c[k])) begin
        t = a[k];
        a[k] = c[k];
        c[k] = t;
      end
    end
    push_beat(test_beat(a[0], a[1], a[2], c[0], c[1], c[2]));
  endtask

  task automatic push_random_plane();
    if ($urandom_range(0, 2) == 0) begin
      push_beat(load_beat($urandom_range(0, 7), '0, '0, '0, '0));
    end else begin
      push_beat(load_beat($urandom_range(0, 7), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord()));
    end
  endtask

  // Receiver: the stall pattern is picked at random among always ready, random ready and occasional long stalls.
  initial begin
    int rx_mode;
    int rx_count;
    int stall_left;
    rx_mode = 0;
    rx_count = 0;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_count++;
      if (rx_count % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 25);
            m_axis_tready <= (stall_left == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_verdict(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    burst_left = 0;
    sb = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Planes that were never loaded are zero and never cull.
    push_beat(test_beat(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    push_beat(load_beat(0, ONE, '0, '0, '0));
    push_beat(test_beat(-2 * ONE, ONE, ONE, -ONE, 2 * ONE, 2 * ONE));
    // The distance is exactly zero here, which must not cull.
    push_beat(test_beat(-2 * ONE, -ONE, -ONE, '0, ONE, ONE));
    // Swapped corners are used as given.
    push_beat(test_beat(ONE, '0, '0, -ONE, '0, '0));
    // Loads past the last plane write nothing but are still acknowledged.
    push_beat(load_beat(6, -ONE, '0, '0, -ONE));
    push_beat(load_beat(7, -ONE, -ONE, -ONE, -ONE));
    push_beat(test_beat(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
    // A negative normal picks the min corner; a zero component picks the min too.
    push_beat(load_beat(3, '0, -ONE, '0, ONE));
    push_beat(test_beat(ONE, 2 * ONE, -ONE, 2 * ONE, 3 * ONE, ONE));
    push_beat(load_beat(5, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    push_beat(test_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    push_beat(test_beat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    push_beat(load_beat(1, '1, '1, '1, '1));
    push_beat(test_beat('0, '0, '0, '0, '0, '0));
    push_beat(test_beat('1, '1, '1, '1, '1, '1));
    push_beat(load_beat(2, '0, '0, '0, '1));
    push_beat(test_beat(ONE, '0, '0, ONE, '0, '0));
    push_beat(load_beat(4, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    push_beat(test_beat(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    push_beat(load_beat(1, '0, '0, '0, '0));
    push_beat(load_beat(2, '0, '0, '0, '0));
    push_beat(test_beat(ONE, -ONE, 32'h8000_0000, 2 * ONE, ONE, 32'h7fff_ffff));

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 2) begin
        // Hold the sender until the pipeline has delivered everything.
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 4) == 0) begin
        push_random_plane();
      end else begin
        push_random_box();
      end
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
